// ----- design/bsm_pkg.sv -----
// Shared types and constants for the bank switch mapper.
package bsm_pkg;

  // Input item opcodes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_CPU_WRITE = 2'd1;
  localparam logic [1:0] OP_CPU_QUERY = 2'd2;
  localparam logic [1:0] OP_PPU_QUERY = 2'd3;

  // Result target codes
  localparam logic [2:0] TGT_UNMAPPED  = 3'd0;
  localparam logic [2:0] TGT_PRG_ROM   = 3'd1;
  localparam logic [2:0] TGT_PRG_RAM   = 3'd2;
  localparam logic [2:0] TGT_CHR_ROM   = 3'd3;
  localparam logic [2:0] TGT_NAMETABLE = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_MASK = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANK_MASK = 1'd1;

  // Mirroring modes
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_SINGLE_HI  = 2'd2;
  localparam logic [1:0] MIRROR_SINGLE_LO  = 2'd3;

  // Write groups selected by address bits 15:12
  localparam logic [3:0] GRP_PRG_LOW  = 4'h8;
  localparam logic [3:0] GRP_MIRROR   = 4'h9;
  localparam logic [3:0] GRP_PRG_HIGH = 4'hA;
  localparam logic [3:0] GRP_CHR_LO   = 4'hB;
  localparam logic [3:0] GRP_CHR_HI   = 4'hE;
  localparam logic [3:0] GRP_IRQ      = 4'hF;

  // IRQ group sub-addresses
  localparam logic [1:0] IRQ_SUB_RELOAD_LO = 2'd0;
  localparam logic [1:0] IRQ_SUB_CONTROL   = 2'd1;
  localparam logic [1:0] IRQ_SUB_RELOAD_HI = 2'd2;
  localparam logic [1:0] IRQ_SUB_ACK       = 2'd3;

  // Fixed upper 16KB window: 16KB bank 0x1F, upper seven bits of the 8KB bank
  localparam logic [6:0] FIXED_BANK_HI = 7'h1F;

  // Prescaler
  localparam int unsigned PRESC_W = 10;
  localparam logic signed [PRESC_W-1:0] PRESCALE_PERIOD = 10'sd341;
  localparam logic signed [PRESC_W-1:0] PRESCALE_STEP   = 10'sd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic        irq_asserted;
    logic [2:0]  target;
    logic [20:0] mapped_address;
  } result_t;

  // Commands from the write decoder to the IRQ counter
  typedef struct packed {
    logic       tick;
    logic       reload_lo;
    logic       reload_hi;
    logic       control;
    logic       ack;
    logic [7:0] data;
  } irq_cmd_t;

endpackage

// ----- design/bsm_irq.sv -----
// IRQ counter with prescaler, latch, control and acknowledge.
module bsm_irq (
  input  logic              clk,
  input  logic              rst,
  input  bsm_pkg::irq_cmd_t cmd,
  output logic              irq_next
);

  logic [2:0]                         control, control_next;
  logic [7:0]                         count, count_next;
  logic [7:0]                         reload, reload_next;
  logic signed [bsm_pkg::PRESC_W-1:0] prescaler, prescaler_next;
  logic signed [bsm_pkg::PRESC_W-1:0] presc_dec;
  logic                               irq_line, irq_line_next;
  logic                               fire;

  always_comb begin
    control_next   = control;
    count_next     = count;
    reload_next    = reload;
    prescaler_next = prescaler;
    irq_line_next  = irq_line;
    fire           = 1'b0;
    presc_dec      = prescaler - bsm_pkg::PRESCALE_STEP;

    // Bit 1 enables counting; bit 2 selects cycle mode over the prescaler.
    if (cmd.tick && control[1]) begin
      if (control[2]) begin
        fire = 1'b1;
      end else if (presc_dec[bsm_pkg::PRESC_W-1]) begin
        prescaler_next = presc_dec + bsm_pkg::PRESCALE_PERIOD;
        fire           = 1'b1;
      end else begin
        prescaler_next = presc_dec;
      end
    end

    if (fire) begin
      if (count == 8'hFF) begin
        count_next    = reload;
        irq_line_next = 1'b1;
      end else begin
        count_next = count + 8'd1;
      end
    end

    if (cmd.reload_lo) begin
      reload_next = {reload[7:4], cmd.data[3:0]};
    end
    if (cmd.reload_hi) begin
      reload_next = {cmd.data[3:0], reload[3:0]};
    end
    if (cmd.control) begin
      control_next  = cmd.data[2:0];
      irq_line_next = 1'b0;
      if (cmd.data[1]) begin
        count_next     = reload;
        prescaler_next = bsm_pkg::PRESCALE_PERIOD;
      end
    end
    if (cmd.ack) begin
      control_next  = {control[2], control[0], control[0]};
      irq_line_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control   <= '0;
      count     <= '0;
      reload    <= '0;
      prescaler <= '0;
      irq_line  <= 1'b0;
    end else begin
      control   <= control_next;
      count     <= count_next;
      reload    <= reload_next;
      prescaler <= prescaler_next;
      irq_line  <= irq_line_next;
    end
  end

  assign irq_next = irq_line_next;

endmodule

// ----- design/bank_switch_mapper_with_scanline_irq.sv -----
// Top level of the cartridge bank mapper with its IRQ counter.
//
// Items arrive on the item channel (valid/ready) and each one yields exactly
// one result on the result channel (valid/ready). An item is a CPU cycle
// tick, a CPU register write, a CPU address query or a PPU address query.
// Every result carries the IRQ line level after that item; queries also
// carry the target memory and the banked byte offset within it.
// An item is held in the input register, then the mapping and IRQ update
// are done in a single pass into the result register.
// Throughput is one item per cycle while the receiver takes results; the
// bank and IRQ state written by one item is in place for the item after it.
// When the receiver stalls, the result register holds its result and the
// input register can still take one more item before item_ready drops.
// The bank mask registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, unenforced.
// Synchronous reset restores the power-up bank layout, sets both masks to
// all ones, clears the IRQ counter and empties both registers.
module bank_switch_mapper_with_scanline_irq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  bsm_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output bsm_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [bsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [7:0]        prg_bank_mask;
  logic [7:0]        chr_bank_mask;
  logic [7:0]        prg_bank_low;
  logic [7:0]        prg_bank_high;
  logic [7:0]        chr_banks [8];
  logic [1:0]        mirror_mode;

  logic              stage_valid;
  bsm_pkg::item_t    stage;
  logic              advance;
  logic              work;

  logic [15:0]       addr;
  logic [3:0]        group;
  logic [1:0]        sub;
  logic              is_write;
  logic [3:0]        chr_offset;
  logic [2:0]        chr_idx;
  logic [7:0]        prg_bank;
  logic [13:0]       ppu_addr;
  logic              page;

  bsm_pkg::irq_cmd_t irq_cmd;
  logic              irq_next;
  bsm_pkg::result_t  result_next;

  assign advance    = !result_valid || result_ready;
  assign item_ready = !stage_valid || advance;
  assign work       = stage_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage <= item;
    end
  end

  // Write decode
  assign addr       = stage.bus_address;
  assign group      = addr[15:12];
  assign sub        = addr[1:0] | addr[3:2];
  assign is_write   = work && (stage.opcode == bsm_pkg::OP_CPU_WRITE);
  assign chr_offset = group - bsm_pkg::GRP_CHR_LO;
  assign chr_idx    = {chr_offset[1:0], sub[0]};

  always_comb begin
    irq_cmd           = '0;
    irq_cmd.tick      = work && (stage.opcode == bsm_pkg::OP_TICK);
    irq_cmd.data      = stage.write_data;
    if (is_write && group == bsm_pkg::GRP_IRQ) begin
      unique case (sub)
        bsm_pkg::IRQ_SUB_RELOAD_LO: irq_cmd.reload_lo = 1'b1;
        bsm_pkg::IRQ_SUB_CONTROL:   irq_cmd.control   = 1'b1;
        bsm_pkg::IRQ_SUB_RELOAD_HI: irq_cmd.reload_hi = 1'b1;
        bsm_pkg::IRQ_SUB_ACK:       irq_cmd.ack       = 1'b1;
        default:                    irq_cmd.ack       = 1'b0;
      endcase
    end
  end

  bsm_irq u_irq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (irq_cmd),
    .irq_next (irq_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_mask <= 8'hFF;
      chr_bank_mask <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsm_pkg::CFG_PRG_BANK_MASK: prg_bank_mask <= cfg_data;
        bsm_pkg::CFG_CHR_BANK_MASK: chr_bank_mask <= cfg_data;
        default:                    prg_bank_mask <= prg_bank_mask;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_low  <= 8'd0;
      prg_bank_high <= 8'd1;
      mirror_mode   <= bsm_pkg::MIRROR_VERTICAL;
      for (int i = 0; i < 8; i++) begin
        chr_banks[i] <= 8'(i);
      end
    end else if (is_write) begin
      if (group == bsm_pkg::GRP_PRG_LOW) begin
        prg_bank_low <= stage.write_data;
      end
      if (group == bsm_pkg::GRP_MIRROR) begin
        mirror_mode <= stage.write_data[1:0];
      end
      if (group == bsm_pkg::GRP_PRG_HIGH) begin
        prg_bank_high <= stage.write_data;
      end
      // Each CHR bank is written a nibble at a time.
      if (group >= bsm_pkg::GRP_CHR_LO && group <= bsm_pkg::GRP_CHR_HI) begin
        if (sub[1]) begin
          chr_banks[chr_idx][7:4] <= stage.write_data[3:0];
        end else begin
          chr_banks[chr_idx][3:0] <= stage.write_data[3:0];
        end
      end
    end
  end

  // Address mapping
  assign ppu_addr = addr[13:0];

  always_comb begin
    unique case (addr[14:13])
      2'b00:   prg_bank = prg_bank_low;
      2'b01:   prg_bank = prg_bank_high;
      default: prg_bank = {bsm_pkg::FIXED_BANK_HI, addr[13]};
    endcase

    unique case (mirror_mode)
      bsm_pkg::MIRROR_VERTICAL:   page = ppu_addr[10];
      bsm_pkg::MIRROR_HORIZONTAL: page = ppu_addr[11];
      bsm_pkg::MIRROR_SINGLE_HI:  page = 1'b1;
      default:                    page = 1'b0;
    endcase

    result_next                = '0;
    result_next.irq_asserted   = irq_next;
    unique case (stage.opcode)
      bsm_pkg::OP_CPU_QUERY: begin
        if (addr[15]) begin
          result_next.target         = bsm_pkg::TGT_PRG_ROM;
          result_next.mapped_address = {prg_bank & prg_bank_mask, addr[12:0]};
        end else if (addr[14:13] == 2'b11) begin
          result_next.target         = bsm_pkg::TGT_PRG_RAM;
          result_next.mapped_address = {8'd0, addr[12:0]};
        end
      end
      bsm_pkg::OP_PPU_QUERY: begin
        if (!ppu_addr[13]) begin
          result_next.target         = bsm_pkg::TGT_CHR_ROM;
          result_next.mapped_address =
            {3'd0, chr_banks[ppu_addr[12:10]] & chr_bank_mask, ppu_addr[9:0]};
        end else begin
          result_next.target         = bsm_pkg::TGT_NAMETABLE;
          result_next.mapped_address = {10'd0, page, ppu_addr[9:0]};
        end
      end
      default: result_next.target = bsm_pkg::TGT_UNMAPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      result <= result_next;
    end
  end

endmodule

// ----- design/bsm_checker.sv -----
// Port-level checks for the bank switch mapper, bound to the top level.
module bsm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input bsm_pkg::result_t                result
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid straight after reset");

  // A result only appears after an item transfer through both registers.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready, 2))
    else $error("result appeared without a matching item transfer");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or vanished");

  // Unmapped results carry no offset.
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.target == bsm_pkg::TGT_UNMAPPED |->
      result.mapped_address == 21'd0)
    else $error("unmapped result with a non-zero offset");

  // Target codes in range; RAM and nametable offsets in their windows.
  a_window: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.target == bsm_pkg::TGT_UNMAPPED || result.target == bsm_pkg::TGT_PRG_ROM ||
       result.target == bsm_pkg::TGT_CHR_ROM ||
       (result.target == bsm_pkg::TGT_PRG_RAM && result.mapped_address[20:13] == 8'd0) ||
       (result.target == bsm_pkg::TGT_NAMETABLE && result.mapped_address[20:11] == 10'd0)))
    else $error("result target or offset out of range");

endmodule

bind bank_switch_mapper_with_scanline_irq bsm_checker u_bsm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ----- tb/sv/tb_bank_switch_mapper_with_scanline_irq.sv -----
// Self-checking testbench for the bank switch mapper with its scanline IRQ counter.
`timescale 1ns / 1ps

module tb_bank_switch_mapper_with_scanline_irq;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 190;

  logic                            clk;
  logic                            rst;
  logic                            item_valid;
  logic                            item_ready;
  bsm_pkg::item_t                  item;
  logic                            result_valid;
  logic                            result_ready;
  bsm_pkg::result_t                result;
  logic                            cfg_we;
  logic [bsm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_data;

  bank_switch_mapper_with_scanline_irq dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  typedef struct {
    bsm_pkg::item_t   stim;
    bit               known;
    bsm_pkg::result_t want;
  } vector_t;

  // Shadow copy of the mapper state.
  logic [7:0]                         prg_mask;
  logic [7:0]                         chr_mask;
  logic [7:0]                         prg_low;
  logic [7:0]                         prg_high;
  logic [7:0]                         chr_bank [8];
  logic [1:0]                         mirror;
  logic [2:0]                         irq_ctl;
  logic [7:0]                         irq_cnt;
  logic [7:0]                         irq_latch;
  logic signed [bsm_pkg::PRESC_W-1:0] presc;
  logic                               irq_out;

  bsm_pkg::result_t pending_results[$];
  vector_t          vectors[$];
  int               mismatches;
  int               cycles;
  int               items_sent;
  bit               send_eager;
  bit               recv_eager;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("bank_switch_mapper_with_scanline_irq test failed");
      $finish;
    end
  end

  function automatic void reset_shadow();
    prg_mask  = 8'hFF;
    chr_mask  = 8'hFF;
    prg_low   = 8'h00;
    prg_high  = 8'h01;
    for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
    mirror    = bsm_pkg::MIRROR_VERTICAL;
    irq_ctl   = '0;
    irq_cnt   = '0;
    irq_latch = '0;
    presc     = '0;
    irq_out   = 1'b0;
  endfunction

  // Applies one item to the shadow state and returns the result it should give.
  function automatic bsm_pkg::result_t map_item(bsm_pkg::item_t it);
    bsm_pkg::result_t r;
    logic       fire;
    logic [3:0] grp;
    logic [3:0] pair;
    logic [1:0] sub;
    logic [3:0] nib;
    logic [2:0] idx;
    logic [7:0] bank;
    logic [15:0] a;
    logic [13:0] pa;
    logic       page;
    r    = '0;
    a    = it.bus_address;
    grp  = a[15:12];
    sub  = a[1:0] | a[3:2];
    nib  = it.write_data[3:0];
    pa   = a[13:0];
    case (it.opcode)
      bsm_pkg::OP_TICK: begin
        fire = 1'b0;
        if (irq_ctl[1]) begin
          if (irq_ctl[2]) begin
            fire = 1'b1;
          end else begin
            presc = presc - bsm_pkg::PRESCALE_STEP;
            if (presc < 0) begin
              presc = presc + bsm_pkg::PRESCALE_PERIOD;
              fire  = 1'b1;
            end
          end
        end
        if (fire) begin
          if (irq_cnt == 8'hFF) begin
            irq_cnt = irq_latch;
            irq_out = 1'b1;
          end else begin
            irq_cnt = irq_cnt + 8'd1;
          end
        end
      end
      bsm_pkg::OP_CPU_WRITE: begin
        if (grp == bsm_pkg::GRP_PRG_LOW) begin
          prg_low = it.write_data;
        end else if (grp == bsm_pkg::GRP_MIRROR) begin
          mirror = it.write_data[1:0];
        end else if (grp == bsm_pkg::GRP_PRG_HIGH) begin
          prg_high = it.write_data;
        end else if (grp >= bsm_pkg::GRP_CHR_LO && grp <= bsm_pkg::GRP_CHR_HI) begin
          pair = grp - bsm_pkg::GRP_CHR_LO;
          idx  = {pair[1:0], sub[0]};
          if (sub[1]) chr_bank[idx][7:4] = nib;
          else chr_bank[idx][3:0] = nib;
        end else if (grp == bsm_pkg::GRP_IRQ) begin
          case (sub)
            bsm_pkg::IRQ_SUB_RELOAD_LO: irq_latch[3:0] = nib;
            bsm_pkg::IRQ_SUB_RELOAD_HI: irq_latch[7:4] = nib;
            bsm_pkg::IRQ_SUB_CONTROL: begin
              irq_ctl = it.write_data[2:0];
              if (irq_ctl[1]) begin
                irq_cnt = irq_latch;
                presc   = bsm_pkg::PRESCALE_PERIOD;
              end
              irq_out = 1'b0;
            end
            default: begin
              irq_ctl[1] = irq_ctl[0];
              irq_out    = 1'b0;
            end
          endcase
        end
      end
      bsm_pkg::OP_CPU_QUERY: begin
        if (a >= 16'h6000 && a < 16'h8000) begin
          r.target         = bsm_pkg::TGT_PRG_RAM;
          r.mapped_address = 21'(a[12:0]);
        end else if (a >= 16'h8000) begin
          if (a < 16'hA000) bank = prg_low;
          else if (a < 16'hC000) bank = prg_high;
          else bank = {bsm_pkg::FIXED_BANK_HI, a[13]};
          bank             = bank & prg_mask;
          r.target         = bsm_pkg::TGT_PRG_ROM;
          r.mapped_address = {bank, a[12:0]};
        end
      end
      default: begin
        if (!pa[13]) begin
          bank             = chr_bank[pa[12:10]] & chr_mask;
          r.target         = bsm_pkg::TGT_CHR_ROM;
          r.mapped_address = 21'({bank, pa[9:0]});
        end else begin
          case (mirror)
            bsm_pkg::MIRROR_VERTICAL:   page = pa[10];
            bsm_pkg::MIRROR_HORIZONTAL: page = pa[11];
            bsm_pkg::MIRROR_SINGLE_HI:  page = 1'b1;
            default:                    page = 1'b0;
          endcase
          r.target         = bsm_pkg::TGT_NAMETABLE;
          r.mapped_address = 21'({page, pa[9:0]});
        end
      end
    endcase
    r.irq_asserted = irq_out;
    return r;
  endfunction

  function automatic bsm_pkg::item_t mk(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
    bsm_pkg::item_t it;
    it.opcode      = op;
    it.bus_address = addr;
    it.write_data  = data;
    return it;
  endfunction

  // Register address in a group whose folded sub-address is the one asked for.
  function automatic logic [15:0] reg_addr(logic [3:0] grp, logic [1:0] sub);
    logic [3:0] lo;
    do lo = 4'($urandom); while ((lo[1:0] | lo[3:2]) != sub);
    return {grp, 8'($urandom), lo};
  endfunction

  task automatic add_vec(bsm_pkg::item_t stim, bit known, bsm_pkg::result_t want);
    vector_t v;
    v.stim  = stim;
    v.known = known;
    v.want  = want;
    vectors.push_back(v);
  endtask

  // Holds the item on the bus until its transfer, then records what it should give.
  task automatic send_item(bsm_pkg::item_t stim, bit known, bsm_pkg::result_t want);
    int               gap;
    bsm_pkg::result_t predicted;
    gap = send_eager ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= stim;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = map_item(stim);
    pending_results.push_back(known ? want : predicted);
    items_sent++;
  endtask

  task automatic send_random(bsm_pkg::item_t stim);
    send_item(stim, 1'b0, '0);
  endtask

  task automatic send_query();
    send_random(mk($urandom_range(0, 1) ? bsm_pkg::OP_CPU_QUERY : bsm_pkg::OP_PPU_QUERY,
                   16'($urandom), 8'($urandom)));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_masks(logic [7:0] prg, logic [7:0] chr);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= bsm_pkg::CFG_PRG_BANK_MASK;
    cfg_data  <= prg;
    @(posedge clk);
    cfg_index <= bsm_pkg::CFG_CHR_BANK_MASK;
    cfg_data  <= chr;
    @(posedge clk);
    cfg_we   <= 1'b0;
    prg_mask = prg;
    chr_mask = chr;
  endtask

  // Mostly well-formed register sequences with random content, some noise.
  task automatic random_phase(int stop_at);
    int         kind;
    int         n;
    logic [7:0] ctl;
    while (items_sent < stop_at) begin
      send_eager = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        send_random(mk(2'($urandom), 16'($urandom), 8'($urandom)));
      end else if (kind < 4) begin
        send_random(mk(bsm_pkg::OP_CPU_WRITE,
                       reg_addr(4'($urandom_range(bsm_pkg::GRP_PRG_LOW, bsm_pkg::GRP_CHR_HI)),
                                2'($urandom)),
                       8'($urandom)));
        n = $urandom_range(1, 4);
        repeat (n) send_query();
      end else if (kind < 7) begin
        send_random(mk(bsm_pkg::OP_CPU_WRITE,
                       reg_addr(bsm_pkg::GRP_IRQ, bsm_pkg::IRQ_SUB_RELOAD_LO), 8'($urandom)));
        send_random(mk(bsm_pkg::OP_CPU_WRITE,
                       reg_addr(bsm_pkg::GRP_IRQ, bsm_pkg::IRQ_SUB_RELOAD_HI),
                       $urandom_range(0, 1) ? 8'hFF : 8'($urandom)));
        ctl    = 8'($urandom);
        ctl[1] = ($urandom_range(0, 3) != 0);
        send_random(mk(bsm_pkg::OP_CPU_WRITE,
                       reg_addr(bsm_pkg::GRP_IRQ, bsm_pkg::IRQ_SUB_CONTROL), ctl));
        // Prescaled counting needs over a hundred ticks per count.
        if (!ctl[2] && $urandom_range(0, 3) == 0) n = 120;
        else n = $urandom_range(1, 12);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) send_query();
          else send_random(mk(bsm_pkg::OP_TICK, 16'($urandom), 8'($urandom)));
        end
        if ($urandom_range(0, 1) == 0)
          send_random(mk(bsm_pkg::OP_CPU_WRITE,
                         reg_addr(bsm_pkg::GRP_IRQ, bsm_pkg::IRQ_SUB_ACK), 8'($urandom)));
      end else begin
        send_query();
      end
    end
  endtask

  task automatic check_result(bsm_pkg::result_t got);
    bsm_pkg::result_t want;
    if (pending_results.size() == 0) begin
      $error("result with none expected: irq_asserted %0d target %0d mapped_address 0x%0h",
             got.irq_asserted, got.target, got.mapped_address);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (got.irq_asserted !== want.irq_asserted) begin
        $error("irq_asserted: expected %0d, actual %0d", want.irq_asserted, got.irq_asserted);
        mismatches++;
      end
      if (got.target !== want.target) begin
        $error("target: expected %0d, actual %0d", want.target, got.target);
        mismatches++;
      end
      if (got.mapped_address !== want.mapped_address) begin
        $error("mapped_address: expected 0x%0h, actual 0x%0h",
               want.mapped_address, got.mapped_address);
        mismatches++;
      end
    end
  endtask

  // Result side: a random stall before each transfer, with eager stretches now and then.
  initial begin
    int gap;
    result_ready = 1'b0;
    recv_eager   = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) recv_eager = ~recv_eager;
      gap = recv_eager ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      check_result(result);
    end
  end

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    mismatches = 0;
    items_sent = 0;
    send_eager = 1'b0;
    reset_shadow();

    // Power-up layout, all address boundaries.
    add_vec(mk(bsm_pkg::OP_CPU_QUERY, 16'h0000, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_QUERY, 16'h6000, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_PRG_RAM, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_QUERY, 16'h8000, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_PRG_ROM, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_QUERY, 16'hBFFF, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_PRG_ROM, 21'h3FFF});
    add_vec(mk(bsm_pkg::OP_CPU_QUERY, 16'hC000, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_PRG_ROM, 21'h7C000});
    add_vec(mk(bsm_pkg::OP_CPU_QUERY, 16'hFFFF, 8'hFF), 1'b1,
            '{1'b0, bsm_pkg::TGT_PRG_ROM, 21'h7FFFF});
    add_vec(mk(bsm_pkg::OP_PPU_QUERY, 16'h0000, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_CHR_ROM, 21'h0});
    add_vec(mk(bsm_pkg::OP_PPU_QUERY, 16'h1FFF, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_CHR_ROM, 21'h1FFF});
    // Top PPU bits are ignored and the upper nametable range mirrors the lower.
    add_vec(mk(bsm_pkg::OP_PPU_QUERY, 16'hFFFF, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_NAMETABLE, 21'h7FF});
    add_vec(mk(bsm_pkg::OP_TICK, 16'hFFFF, 8'hFF), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    // A write below the register range changes nothing.
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'h7FFF, 8'hFF), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'h8000, 8'hFF), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hA00F, 8'h80), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'h9000, 8'hFF), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hB004, 8'hAB), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hE00A, 8'h5C), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hC003, 8'h07), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_QUERY, 16'h9ABC, 8'h00), 1'b0, '0);
    add_vec(mk(bsm_pkg::OP_PPU_QUERY, 16'h1BFF, 8'h00), 1'b0, '0);
    add_vec(mk(bsm_pkg::OP_PPU_QUERY, 16'h2C00, 8'h00), 1'b0, '0);
    add_vec(mk(bsm_pkg::OP_PPU_QUERY, 16'h0400, 8'h00), 1'b0, '0);
    // Acknowledge before any enable, then a fast count up to overflow.
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hF003, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hF000, 8'hFE), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hF008, 8'h0F), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hF001, 8'h06), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_TICK, 16'h0000, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_TICK, 16'h0000, 8'h00), 1'b1,
            '{1'b1, bsm_pkg::TGT_UNMAPPED, 21'h0});
    add_vec(mk(bsm_pkg::OP_CPU_WRITE, 16'hF00C, 8'h00), 1'b1,
            '{1'b0, bsm_pkg::TGT_UNMAPPED, 21'h0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i]) send_item(vectors[i].stim, vectors[i].known, vectors[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_masks(8'h00, 8'h00);
        1:       write_masks(8'hFF, 8'hFF);
        2:       write_masks(8'($urandom), 8'($urandom));
        default: write_masks(8'h1F, 8'h07);
      endcase
      random_phase(items_sent + PHASE_ITEMS);
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("bank_switch_mapper_with_scanline_irq test passed");
    end else begin
      $display("bank_switch_mapper_with_scanline_irq test failed");
    end
    $finish;
  end

endmodule
